// ----- rtl/ols_pkg.sv -----
// ============================================================================
// ols_pkg: shared codes for the ordered list block
// Command and status codes used by the list sequencer and its port checker.
// ============================================================================
`default_nettype none

package ols_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 7;

  // command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE    = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd2;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/ols_mem.sv -----
// ============================================================================
// ols_mem: list entry storage
// Single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module ols_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [ols_pkg::ValueW-1:0]   wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [ols_pkg::ValueW-1:0]   rdata
);

  logic [ols_pkg::ValueW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ordered_list_insert_search_delete_top.sv -----
// ============================================================================
// ordered_list_insert_search_delete_top: ordered list with insert/search/delete
// Sequencer that walks and shifts a RAM-held list one entry at a time.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: command,
//   value and position. Output channel (out_valid/out_ready) carries one
//   result beat per command: status and found_position.
//   One command is in flight at a time; in_ready is high only while the
//   sequencer is idle. Every step reads the single RAM read port and waits
//   for the registered read data before it compares or writes an entry:
//     search : compares entries from the head, up to count of them
//     delete : compares up to the match, then shifts the later entries down
//     insert : shifts entries from the tail down to the insert slot
//     errors, empty list, unused code three : straight to the result
//   The result sits in an output register; a stalled receiver holds the
//   sequencer in its finish step only if a new result is ready before the
//   old one is taken. Reset (rst, synchronous) empties the list and drops
//   any pending result; entry contents are not cleared.
// ============================================================================
`default_nettype none

module ordered_list_insert_search_delete_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ols_pkg::CmdW-1:0]       command,
  input  wire logic signed [ols_pkg::ValueW-1:0] value,
  input  wire logic [ols_pkg::PosW-1:0]       position,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ols_pkg::StatusW-1:0]         status,
  output logic [ols_pkg::PosW-1:0]            found_position
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // width wide enough to compare position against count + 1
  localparam int unsigned PW = ((CW > ols_pkg::PosW) ? CW : ols_pkg::PosW) + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_WALK_RD = 8'b0000_0010,
    S_WALK_CP = 8'b0000_0100,
    S_DEL_RD  = 8'b0000_1000,
    S_DEL_WR  = 8'b0001_0000,
    S_INS_RD  = 8'b0010_0000,
    S_INS_WR  = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t                       state, state_next;
  logic [AW-1:0]                idx, idx_next;
  logic [AW-1:0]                target, target_next;
  logic [CW-1:0]                count, count_next;
  logic [ols_pkg::ValueW-1:0]   key, key_next;
  logic [ols_pkg::CmdW-1:0]     cmd, cmd_next;
  logic [ols_pkg::StatusW-1:0]  res_status, res_status_next;
  logic [ols_pkg::PosW-1:0]     res_found, res_found_next;
  logic                         out_load;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [ols_pkg::ValueW-1:0]   mem_wdata, mem_rdata;

  logic [CW-1:0]                idx_inc;
  logic [PW-1:0]                pos_ext, limit_ext;

  assign idx_inc   = CW'(idx) + CW'(1);
  assign pos_ext   = PW'(position);
  assign limit_ext = PW'(count) + PW'(1);
  assign in_ready  = (state == S_IDLE);

  ols_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    target_next     = target;
    count_next      = count;
    key_next        = key;
    cmd_next        = cmd;
    res_status_next = res_status;
    res_found_next  = res_found;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = key;
    mem_re          = 1'b0;
    mem_raddr       = idx;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next        = value;
          cmd_next        = command;
          res_status_next = ols_pkg::ST_OK;
          res_found_next  = '0;
          state_next      = S_FINISH;
          unique case (command) inside
            ols_pkg::CMD_INSERT: begin
              if (position == '0 || pos_ext > limit_ext) begin
                res_status_next = ols_pkg::ST_RANGE;
              end else if (count == CW'(DEPTH)) begin
                res_status_next = ols_pkg::ST_FULL;
              end else begin
                // shift from the tail down to the insert slot
                target_next = AW'(pos_ext - PW'(1));
                idx_next    = AW'(count);
                state_next  = S_INS_RD;
              end
            end
            ols_pkg::CMD_SEARCH, ols_pkg::CMD_DELETE: begin
              if (count == '0) begin
                res_status_next = ols_pkg::ST_NOTFOUND;
              end else begin
                idx_next   = '0;
                state_next = S_WALK_RD;
              end
            end
            default: begin
              // unused code: no change, plain ok result
            end
          endcase
        end
      end

      S_WALK_RD: begin
        mem_re     = 1'b1;
        state_next = S_WALK_CP;
      end

      S_WALK_CP: begin
        if (mem_rdata == key) begin
          if (cmd == ols_pkg::CMD_SEARCH) begin
            res_found_next = ols_pkg::PosW'(idx_inc);
            state_next     = S_FINISH;
          end else begin
            state_next = S_DEL_RD;
          end
        end else if (idx_inc == count) begin
          res_status_next = ols_pkg::ST_NOTFOUND;
          state_next      = S_FINISH;
        end else begin
          idx_next   = AW'(idx_inc);
          state_next = S_WALK_RD;
        end
      end

      S_DEL_RD: begin
        if (idx_inc < count) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(idx_inc);
          state_next = S_DEL_WR;
        end else begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end
      end

      S_DEL_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        idx_next   = AW'(idx_inc);
        state_next = S_DEL_RD;
      end

      S_INS_RD: begin
        if (idx > target) begin
          mem_re     = 1'b1;
          mem_raddr  = idx - AW'(1);
          state_next = S_INS_WR;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          state_next = S_FINISH;
        end
      end

      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        idx_next   = idx - AW'(1);
        state_next = S_INS_RD;
      end

      S_FINISH: begin
        // hold here only while an older result is still waiting
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    target     <= target_next;
    key        <= key_next;
    cmd        <= cmd_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (out_load) begin
      status         <= res_status;
      found_position <= res_found;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ols_chk.sv -----
// ============================================================================
// ols_chk: port checker for the ordered list block
// Watches the top level ports and flags broken handshake or result rules.
// ============================================================================
`default_nettype none

module ols_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ols_pkg::StatusW-1:0]   status,
  input wire logic [ols_pkg::PosW-1:0]      found_position
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_position))
    else $error("result beat changed while stalled");

  // only a successful search reports a position
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_position != '0 |-> status == ols_pkg::ST_OK)
    else $error("found_position set on a failed command");

  // one command at a time: accepting a beat closes the input
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ordered_list_insert_search_delete_top ols_chk u_ols_chk (.*);

`default_nettype wire
